// File: rtl/bfs_pkg.sv
// Shared types and constants for the packed bit-field store.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bfs_pkg;

   localparam int IDX_BITS       = 15;
   localparam int WIDTH_BITS     = 7;
   localparam int VAL_BITS       = 64;
   localparam int POS_BITS       = IDX_BITS + WIDTH_BITS;
   localparam int MAX_ADDR_BITS  = 16;
   localparam int MAX_SHIFT_BITS = 6;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd8;

   typedef struct packed {
      logic                cmd;
      logic [IDX_BITS-1:0] element_index;
      logic [VAL_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [VAL_BITS-1:0] read_value;
      logic                range_error;
   } rsp_type;

   // classified transaction handed from the front to the back
   typedef struct packed {
      logic                      is_write;
      logic                      is_err;
      logic [WIDTH_BITS-1:0]     width;
      logic [MAX_ADDR_BITS-1:0]  word;
      logic [MAX_SHIFT_BITS-1:0] shift;
      logic [VAL_BITS-1:0]       value;
   } job_type;

endpackage

// File: rtl/bfs_front.sv
// Front end: accepts a transaction, computes bit position, range check,
// word address and shift. Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_front import bfs_pkg::*; #(
   parameter int WORD_BITS  = 32,
   parameter int MEM_WORDS  = 1024,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic [WIDTH_BITS-1:0] cfg_width,
   output logic                  push,
   output job_type               push_job,
   input  logic                  full
);

   localparam int TOTAL      = MEM_WORDS * WORD_BITS;
   localparam int TOT_BITS   = $clog2(TOTAL + 1);
   localparam int CMP_BITS   = (POS_BITS + 1 > TOT_BITS) ? POS_BITS + 1 : TOT_BITS;
   localparam int RECIP      = (2 ** POS_BITS) / WORD_BITS;
   localparam int RECIP_BITS = $clog2(RECIP + 1);
   localparam int PROD_BITS  = POS_BITS + RECIP_BITS;
   localparam int SH_BITS    = $clog2(WORD_BITS);
   localparam int REM_BITS   = SH_BITS + 1;

   localparam logic [CMP_BITS-1:0]   TOTAL_C   = CMP_BITS'(TOTAL);
   localparam logic [RECIP_BITS-1:0] RECIP_C   = RECIP_BITS'(RECIP);
   localparam logic [POS_BITS-1:0]   WB_POS    = POS_BITS'(WORD_BITS);
   localparam logic [REM_BITS-1:0]   WB_REM    = REM_BITS'(WORD_BITS);
   localparam logic [WIDTH_BITS-1:0] WIDTH_CAP = WIDTH_BITS'(VALUE_BITS);

   localparam logic [1:0] FS_IDLE = 2'd0;
   localparam logic [1:0] FS_POS  = 2'd1;
   localparam logic [1:0] FS_QUOT = 2'd2;
   localparam logic [1:0] FS_PUSH = 2'd3;

   logic [1:0]            phase_ff, phase_in;
   req_type               req_ff, req_in;
   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  err_ff, err_in;
   logic [RECIP_BITS-1:0] quot_ff, quot_in;

   logic [WIDTH_BITS-1:0] eff_width;
   logic [CMP_BITS-1:0]   end_pos;
   logic [PROD_BITS-1:0]  recip_prod;
   logic [POS_BITS-1:0]   quot_times_wb;
   logic [POS_BITS-1:0]   rem_full;
   logic [REM_BITS-1:0]   rem_raw;
   logic [RECIP_BITS-1:0] word_q;
   logic [REM_BITS-1:0]   shift_q;

   assign eff_width     = (cfg_width > WIDTH_CAP) ? WIDTH_CAP : cfg_width;
   assign end_pos       = CMP_BITS'(pos_ff) + CMP_BITS'(width_ff);
   assign recip_prod    = PROD_BITS'(pos_ff) * PROD_BITS'(RECIP_C);
   assign quot_times_wb = POS_BITS'(quot_ff) * WB_POS;
   assign rem_full      = pos_ff - quot_times_wb;
   assign rem_raw       = rem_full[REM_BITS-1:0];

   // reciprocal quotient is low by at most one
   always_comb begin
      if (rem_raw >= WB_REM) begin
         word_q  = quot_ff + RECIP_BITS'(1);
         shift_q = rem_raw - WB_REM;
      end else begin
         word_q  = quot_ff;
         shift_q = rem_raw;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      req_in   = req_ff;
      width_in = width_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      quot_in  = quot_ff;
      push     = 1'b0;
      unique case (phase_ff)
         FS_IDLE: begin
            if (start) begin
               req_in   = req_data;
               width_in = eff_width;
               phase_in = FS_POS;
            end
         end
         FS_POS: begin
            pos_in   = POS_BITS'(req_ff.element_index) * POS_BITS'(width_ff);
            phase_in = FS_QUOT;
         end
         FS_QUOT: begin
            err_in   = end_pos > TOTAL_C;
            quot_in  = recip_prod[POS_BITS +: RECIP_BITS];
            phase_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               phase_in = FS_IDLE;
            end
         end
         default: phase_in = FS_IDLE;
      endcase
   end

   always_comb begin
      push_job.is_write = (req_ff.cmd == CMD_WRITE);
      push_job.is_err   = err_ff;
      push_job.width    = width_ff;
      push_job.word     = MAX_ADDR_BITS'(word_q);
      push_job.shift    = MAX_SHIFT_BITS'(shift_q);
      push_job.value    = req_ff.write_value;
   end

   assign busy = (phase_ff != FS_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= FS_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      width_ff <= width_in;
      pos_ff   <= pos_in;
      err_ff   <= err_in;
      quot_ff  <= quot_in;
   end

endmodule

// File: rtl/bfs_queue.sv
// Two-entry transaction queue between front and back.
// Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_queue import bfs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] DEPTH_C  = CNT_BITS'(DEPTH);

   job_type               entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/bfs_back.sv
// Back end: word memory and the per-word read / merge sequencer.
// Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_back import bfs_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int MEM_WORDS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    empty,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int ADDR_BITS = $clog2(MEM_WORDS);
   localparam int REM_BITS  = WIDTH_BITS + 1;

   localparam logic [REM_BITS-1:0] WB_REM = REM_BITS'(WORD_BITS);

   localparam logic [1:0] BS_IDLE = 2'd0;
   localparam logic [1:0] BS_RD   = 2'd1;
   localparam logic [1:0] BS_MRG  = 2'd2;

   logic [WORD_BITS-1:0] mem [MEM_WORDS];

   logic [1:0]           state_ff, state_in;
   logic                 strobe_ff, strobe_in;
   job_type              job_ff, job_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [REM_BITS-1:0]  off_ff, off_in;
   logic                 first_ff, first_in;
   logic [VAL_BITS-1:0]  acc_ff, acc_in;
   rsp_type              rsp_ff, rsp_in;
   logic [WORD_BITS-1:0] rdata_ff;

   logic                 mem_re;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [VAL_BITS-1:0]  wmask;
   logic [VAL_BITS-1:0]  word_ext;
   logic [VAL_BITS-1:0]  seg;
   logic [WORD_BITS-1:0] ins;
   logic [WORD_BITS-1:0] bmask;
   logic [VAL_BITS-1:0]  acc_next;

   assign wmask    = ~({VAL_BITS{1'b1}} << job_ff.width);
   assign word_ext = VAL_BITS'(rdata_ff);

   always_comb begin
      if (first_ff) begin
         seg   = word_ext >> job_ff.shift;
         ins   = WORD_BITS'(job_ff.value << job_ff.shift);
         bmask = WORD_BITS'(wmask << job_ff.shift);
      end else begin
         seg   = word_ext << off_ff;
         ins   = WORD_BITS'(job_ff.value >> off_ff);
         bmask = WORD_BITS'(wmask >> off_ff);
      end
   end

   assign acc_next  = acc_ff | seg;
   assign mem_wdata = (rdata_ff & ~bmask) | (ins & bmask);

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      job_in    = job_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      off_in    = off_ff;
      first_in  = first_ff;
      acc_in    = acc_ff;
      rsp_in    = rsp_ff;
      pop       = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         BS_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               job_in = head_job;
               if (head_job.is_err || (head_job.width == '0)) begin
                  strobe_in          = 1'b1;
                  rsp_in.read_value  = '0;
                  rsp_in.range_error = head_job.is_err;
               end else begin
                  addr_in  = head_job.word[ADDR_BITS-1:0];
                  rem_in   = REM_BITS'(head_job.shift) + REM_BITS'(head_job.width);
                  off_in   = '0;
                  first_in = 1'b1;
                  acc_in   = '0;
                  state_in = BS_RD;
               end
            end
         end
         BS_RD: begin
            mem_re   = 1'b1;
            state_in = BS_MRG;
         end
         BS_MRG: begin
            mem_we = job_ff.is_write;
            acc_in = acc_next;
            if (rem_ff <= WB_REM) begin
               strobe_in          = 1'b1;
               rsp_in.read_value  = job_ff.is_write ? '0 : (acc_next & wmask);
               rsp_in.range_error = 1'b0;
               state_in           = BS_IDLE;
            end else begin
               rem_in   = rem_ff - WB_REM;
               addr_in  = addr_ff + ADDR_BITS'(1);
               off_in   = first_ff ? (WB_REM - REM_BITS'(job_ff.shift)) : (off_ff + WB_REM);
               first_in = 1'b0;
               state_in = BS_RD;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BS_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      addr_ff  <= addr_in;
      rem_ff   <= rem_in;
      off_ff   <= off_in;
      first_ff <= first_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/bitpacked_field_store.sv
// Top level of the packed bit-field store: width register, front end,
// queue and back end. Depends on bfs_pkg, bfs_front, bfs_queue, bfs_back.
//
//   channel  ports                      handshake
//   request  start, busy, req_data      taken when start && !busy
//   result   rsp_strobe, rsp_data       one cycle per result, no backpressure
//   config   csr_valid, csr_ready,      written when csr_valid && csr_ready
//            csr_wdata
//
// The front steps through capture, position multiply, reciprocal multiply
// and range check, and queue push, which waits while the queue is full.
// The back dispatches, then reads and merges/writes back each memory word
// the element spans; flagged or zero-width transactions end at dispatch.
// Sustained rate is the slower of the two; neither overlaps transactions.
// Synchronous reset clears control state and sets the width to 8; memory
// contents are undefined until written. Results cannot be stalled.
`timescale 1ns / 1ps

module bitpacked_field_store import bfs_pkg::*; #(
   parameter int WORD_BITS  = 32,
   parameter int MEM_WORDS  = 1024,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_wdata
);

   logic [WIDTH_BITS-1:0] bit_width_ff, bit_width_in;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_empty;
   job_type               q_push_job;
   job_type               q_head_job;

   assign csr_ready    = 1'b1;
   assign bit_width_in = (csr_valid && csr_ready) ? csr_wdata : bit_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_width_ff <= WIDTH_RESET;
      end else begin
         bit_width_ff <= bit_width_in;
      end
   end

   bfs_front #(
      .WORD_BITS  (WORD_BITS),
      .MEM_WORDS  (MEM_WORDS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg_width (bit_width_ff),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full)
   );

   bfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (q_head_job)
   );

   bfs_back #(
      .WORD_BITS (WORD_BITS),
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("front not busy after accepting a transaction");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("pop from empty queue");
`endif

endmodule

// File: tb/sv/tb_bitpacked_field_store.sv
// Self-checking testbench for bitpacked_field_store: directed and random element
// reads and writes at several widths. The scoreboard class predicts each response.
// Depends on bfs_pkg and the bitpacked_field_store RTL.
`timescale 1ns / 1ps

module tb_bitpacked_field_store;
   import bfs_pkg::*;

   localparam int MEM_BITS     = 32 * 1024;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 125;
   localparam int DRAIN_CYCLES = 24;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_strobe;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [WIDTH_BITS-1:0] csr_wdata;

   class field_store_board;
      bit [WIDTH_BITS-1:0] width_reg;
      bit                  mem_bits [MEM_BITS];
      bit                  bit_written [MEM_BITS];
      rsp_type             pending_rsp [$];
      int                  mismatches;

      function new();
         width_reg  = WIDTH_RESET;
         mismatches = 0;
      endfunction

      // widths above the value size saturate
      function int unsigned field_width();
         return (width_reg > VAL_BITS) ? VAL_BITS : width_reg;
      endfunction

      function int unsigned max_index();
         return (field_width() == 0) ? 32767 : MEM_BITS / field_width() - 1;
      endfunction

      function bit in_range(int unsigned idx);
         return idx * field_width() + field_width() <= MEM_BITS;
      endfunction

      // flagged elements touch no memory, so they are always safe to read
      function bit readable(int unsigned idx);
         int unsigned w;
         int unsigned pos;
         int unsigned i;
         w   = field_width();
         pos = idx * w;
         if (!in_range(idx)) return 1'b1;
         for (i = 0; i < w; i++)
            if (!bit_written[pos + i]) return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(req_type r);
         rsp_type     exp;
         int unsigned w;
         int unsigned pos;
         int unsigned i;
         w   = field_width();
         pos = r.element_index * w;
         exp = '0;
         if (!in_range(r.element_index)) begin
            exp.range_error = 1'b1;
         end else if (r.cmd == CMD_WRITE) begin
            for (i = 0; i < w; i++) begin
               mem_bits[pos + i]    = r.write_value[i];
               bit_written[pos + i] = 1'b1;
            end
         end else begin
            for (i = 0; i < w; i++)
               exp.read_value[i] = mem_bits[pos + i];
         end
         pending_rsp.push_back(exp);
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, got value %h error %b",
                     $time, got.read_value, got.range_error);
            mismatches++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.read_value !== exp.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, exp.read_value, got.read_value);
            mismatches++;
         end
         if (got.range_error !== exp.range_error) begin
            $display("%0t: range_error expected %b actual %b",
                     $time, exp.range_error, got.range_error);
            mismatches++;
         end
      endfunction
   endclass

   field_store_board board;
   bit               calm;
   int unsigned      window_base;

   bitpacked_field_store u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp_data);
         if (start && !busy) board.note_request(req_data);
      end
   end

   task automatic issue(input logic cmd, input int unsigned idx, input logic [63:0] val);
      req_type r;
      r.cmd           = cmd;
      r.element_index = idx[IDX_BITS-1:0];
      r.write_value   = val;
      if (!calm && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.width_reg = v;
   endtask

   function automatic int unsigned near_index();
      int unsigned idx;
      idx = window_base + $urandom_range(47);
      return (idx > board.max_index()) ? board.max_index() : idx;
   endfunction

   function automatic logic [WIDTH_BITS-1:0] phase_width(input int p);
      case (p)
         0:       return 7'd1;
         1:       return 7'd64;
         2:       return 7'd7;
         3:       return 7'd32;
         4:       return 7'd33;
         5:       return 7'd0;
         6:       return 7'd90;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   task automatic random_item();
      int unsigned max_ok;
      int unsigned idx;
      int unsigned kind;
      int unsigned tries;
      logic        cmd;
      logic [63:0] val;
      max_ok = board.max_index();
      val    = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       val = '1;
         1:       val = '0;
         default: ;
      endcase
      kind = $urandom_range(99);
      cmd  = CMD_WRITE;
      if (kind < 45) begin
         idx = near_index();
      end else if (kind < 85) begin
         cmd   = CMD_READ;
         idx   = near_index();
         tries = 0;
         while (!board.readable(idx) && tries < 8) begin
            idx = near_index();
            tries++;
         end
      end else if (kind < 93) begin
         cmd = ($urandom_range(1) == 1) ? CMD_WRITE : CMD_READ;
         idx = (max_ok < 32767) ? $urandom_range(32767, max_ok + 1) : $urandom_range(32767);
      end else begin
         cmd = ($urandom_range(1) == 1) ? CMD_WRITE : CMD_READ;
         idx = $urandom_range(max_ok);
      end
      if (!board.readable(idx)) cmd = CMD_WRITE;
      issue(cmd, idx, val);
   endtask

   initial begin
      int p;
      int n;
      board = new();
      calm  = 1'b0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset width, neighbors, last element and past the end
      issue(CMD_WRITE, 0, '1);
      issue(CMD_WRITE, 1, '0);
      issue(CMD_READ, 0, '0);
      issue(CMD_READ, 1, '1);
      issue(CMD_WRITE, 4095, 64'h0123_4567_89AB_CDEF);
      issue(CMD_READ, 4095, '0);
      issue(CMD_WRITE, 4096, '1);
      issue(CMD_READ, 4096, '0);
      issue(CMD_WRITE, 32767, '1);

      write_width(7'd0);
      issue(CMD_WRITE, 5, '1);
      issue(CMD_READ, 32767, '0);

      write_width(7'd64);
      issue(CMD_WRITE, 0, '1);
      issue(CMD_WRITE, 1, 64'hA5A5_5A5A_F00F_0FF0);
      issue(CMD_READ, 0, '0);
      issue(CMD_READ, 1, '0);
      issue(CMD_WRITE, 511, 64'h8000_0000_0000_0001);
      issue(CMD_READ, 511, '0);
      issue(CMD_READ, 512, '0);

      // above the value size: saturates
      write_width(7'd127);
      issue(CMD_READ, 1, '0);
      issue(CMD_WRITE, 2, '0);

      // element spanning three words
      write_width(7'd60);
      issue(CMD_WRITE, 1, 64'hFEDC_BA98_7654_3210);
      issue(CMD_READ, 1, '0);

      write_width(7'd1);
      issue(CMD_WRITE, 32767, '1);
      issue(CMD_READ, 32767, '0);

      for (p = 0; p < PHASES; p++) begin
         write_width(phase_width(p));
         calm = (p == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) window_base = $urandom_range(board.max_index());
            random_item();
         end
      end
      calm = 1'b0;

      drain();
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
